// File: rtl/ramp_pkg.sv
// ----------------------------------------------------------------------------
// ramp_pkg: shared constants and types of the radial alpha mask
// field widths, reciprocal for the percent scaling and configuration flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ramp_pkg;

  localparam int COORD_W        = 11;
  localparam int ALPHA_W        = 8;
  localparam int RADIUS_W       = 10;
  localparam int PCT_W          = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;
  localparam int MAX_RADIUS_DEF = 1024;

  // fraction bits of the distance square root
  localparam int FRAC_W = 8;

  // squared distance of two coordinate differences
  localparam int DIST_W = 2 * COORD_W + 1;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2**17
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((2 ** RECIP_SHIFT + 99) / 100);

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = '0;

  typedef struct packed {
    logic hole_enable;
    logic fade_enable;
    logic squared_falloff;
  } cfg_flags_t;

endpackage

`default_nettype wire

// File: rtl/ramp_cfg.sv
// ----------------------------------------------------------------------------
// ramp_cfg: configuration registers and derived mask geometry
// holds the six registers and works out radius, edges and divisors over
// four free-running register steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ramp_cfg #(
  parameter int MAX_RADIUS = ramp_pkg::MAX_RADIUS_DEF,
  parameter int RW         = ramp_pkg::RADIUS_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ramp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ramp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [RW-1:0]                       radius,
  output logic [2*RW-1:0]                     radius_sq,
  output logic [2*RW+1:0]                     hole_sq,
  output logic [2*RW+1:0]                     fade_sq,
  output logic [RW+ramp_pkg::FRAC_W-1:0]      lin_den,
  output logic [2*RW-1:0]                     sq_den,
  output ramp_pkg::cfg_flags_t                flags
);

  localparam int HW = RW + 1;
  localparam int PW = RW + ramp_pkg::PCT_W;
  localparam int MW = PW + ramp_pkg::RECIP_W;

  localparam int SAT_VAL = (MAX_RADIUS - 1 < 2 ** ramp_pkg::RADIUS_W) ?
                           MAX_RADIUS - 1 : 2 ** ramp_pkg::RADIUS_W - 1;
  localparam logic [ramp_pkg::RADIUS_W-1:0] SAT_LIMIT = ramp_pkg::RADIUS_W'(SAT_VAL);

  localparam logic [ramp_pkg::RADIUS_W-1:0] RADIUS_RST = ramp_pkg::RADIUS_W'(64);

  typedef enum logic [ramp_pkg::CFG_IDX_W-1:0] {
    CFG_MASK_RADIUS     = 3'd0,
    CFG_HOLE_PERCENT    = 3'd1,
    CFG_FADE_PERCENT    = 3'd2,
    CFG_HOLE_ENABLE     = 3'd3,
    CFG_FADE_ENABLE     = 3'd4,
    CFG_SQUARED_FALLOFF = 3'd5
  } cfg_idx_t;

  logic [ramp_pkg::RADIUS_W-1:0] mask_radius_r;
  logic [ramp_pkg::PCT_W-1:0]    hole_percent_r;
  logic [ramp_pkg::PCT_W-1:0]    fade_percent_r;
  logic                          hole_enable_r;
  logic                          fade_enable_r;
  logic                          squared_falloff_r;

  logic [2*RW-1:0] radius_sq_r;
  logic [PW-1:0]   hole_prod_r;
  logic [PW-1:0]   fade_prod_r;
  logic [HW-1:0]   hole_r;
  logic [HW-1:0]   fade_r;
  logic [2*HW-1:0] hole_sq_r;
  logic [2*HW-1:0] fade_sq_r;
  logic [RW+ramp_pkg::FRAC_W-1:0] lin_den_r;
  logic [2*RW-1:0] sq_den_r;

  logic [MW-1:0] hole_mul;
  logic [MW-1:0] fade_mul;
  logic [RW-1:0] fade_gap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_radius_r     <= RADIUS_RST;
      hole_percent_r    <= '0;
      fade_percent_r    <= '0;
      hole_enable_r     <= 1'b0;
      fade_enable_r     <= 1'b0;
      squared_falloff_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASK_RADIUS:     mask_radius_r     <= cfg_data[ramp_pkg::RADIUS_W-1:0];
        CFG_HOLE_PERCENT:    hole_percent_r    <= cfg_data[ramp_pkg::PCT_W-1:0];
        CFG_FADE_PERCENT:    fade_percent_r    <= cfg_data[ramp_pkg::PCT_W-1:0];
        CFG_HOLE_ENABLE:     hole_enable_r     <= cfg_data[0];
        CFG_FADE_ENABLE:     fade_enable_r     <= cfg_data[0];
        CFG_SQUARED_FALLOFF: squared_falloff_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // radius saturates one below the maximum
  assign radius = (mask_radius_r > SAT_LIMIT) ? SAT_LIMIT[RW-1:0] : mask_radius_r[RW-1:0];

  assign hole_mul = MW'(hole_prod_r) * MW'(ramp_pkg::RECIP_100);
  assign fade_mul = MW'(fade_prod_r) * MW'(ramp_pkg::RECIP_100);
  assign fade_gap = radius - fade_r[RW-1:0];

  always_ff @(posedge clk) begin
    // step one: products of the radius
    radius_sq_r <= (2*RW)'(radius) * (2*RW)'(radius);
    hole_prod_r <= PW'(radius) * PW'(hole_percent_r);
    fade_prod_r <= PW'(radius) * PW'(fade_percent_r);
    // step two: divide by one hundred
    hole_r      <= hole_mul[ramp_pkg::RECIP_SHIFT +: HW];
    fade_r      <= fade_mul[ramp_pkg::RECIP_SHIFT +: HW];
    // step three: squared edges and the linear divisor
    hole_sq_r   <= (2*HW)'(hole_r) * (2*HW)'(hole_r);
    fade_sq_r   <= (2*HW)'(fade_r) * (2*HW)'(fade_r);
    lin_den_r   <= {fade_gap, {ramp_pkg::FRAC_W{1'b0}}};
    // step four: squared divisor
    sq_den_r    <= radius_sq_r - fade_sq_r[2*RW-1:0];
  end

  assign radius_sq = radius_sq_r;
  assign hole_sq   = hole_sq_r;
  assign fade_sq   = fade_sq_r;
  assign lin_den   = lin_den_r;
  assign sq_den    = sq_den_r;

  assign flags.hole_enable     = hole_enable_r;
  assign flags.fade_enable     = fade_enable_r;
  assign flags.squared_falloff = squared_falloff_r;

endmodule

`default_nettype wire

// File: rtl/ramp_sqrt.sv
// ----------------------------------------------------------------------------
// ramp_sqrt: pipelined integer square root of the squared distance
// one result bit per stage, with eight fraction bits, side data alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ramp_sqrt #(
  parameter int RW     = ramp_pkg::RADIUS_W,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [2*RW-1:0]               in_op,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [RW+ramp_pkg::FRAC_W-1:0] out_root,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int SW = RW + ramp_pkg::FRAC_W;
  localparam int XW = 2 * SW;

  logic [SW-1:0]     v_r;
  logic [XW-1:0]     rem_r    [SW];
  logic [SW-1:0]     root_r   [SW];
  logic [SIDE_W-1:0] side_r   [SW];
  logic [XW-1:0]     rem_nxt  [SW];
  logic [SW-1:0]     root_nxt [SW];
  logic [SIDE_W-1:0] side_nxt [SW];

  // each stage tries the next lower root bit against the remainder
  always_comb begin
    logic [XW-1:0] rem_cur;
    logic [SW-1:0] root_cur;
    logic [XW-1:0] trial;
    logic          fits;
    for (int j = 0; j < SW; j++) begin
      if (j == 0) begin
        rem_cur     = {in_op, {(2*ramp_pkg::FRAC_W){1'b0}}};
        root_cur    = '0;
        side_nxt[j] = in_side;
      end else begin
        rem_cur     = rem_r[j-1];
        root_cur    = root_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      trial       = (XW'(root_cur) << (SW - j)) | (XW'(1) << (2 * (SW - 1 - j)));
      fits        = rem_cur >= trial;
      rem_nxt[j]  = fits ? rem_cur - trial : rem_cur;
      root_nxt[j] = fits ? (root_cur | (SW'(1) << (SW - 1 - j))) : root_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SW; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign out_valid = v_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_side  = side_r[SW-1];

`ifndef NO_ASSERTIONS
  // finished root is the floor: the remainder stays within twice the root
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SW-1] |-> rem_r[SW-1] <= XW'({root_r[SW-1], 1'b0}))
    else $error("square root remainder too large");
`endif

endmodule

`default_nettype wire

// File: rtl/ramp_div.sv
// ----------------------------------------------------------------------------
// ramp_div: pipelined restoring divider for the fade alpha
// one quotient bit per stage, eight stages, side data alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ramp_div #(
  parameter int DW     = 2 * ramp_pkg::RADIUS_W,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DW+ramp_pkg::ALPHA_W-1:0] in_num,
  input  logic [DW-1:0]               in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [ramp_pkg::ALPHA_W-1:0] out_quot,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int QW = ramp_pkg::ALPHA_W;
  localparam int NW = DW + QW;

  logic [QW-1:0]     v_r;
  logic [NW-1:0]     rem_r    [QW];
  logic [DW-1:0]     den_r    [QW];
  logic [QW-1:0]     quot_r   [QW];
  logic [SIDE_W-1:0] side_r   [QW];
  logic [NW-1:0]     rem_nxt  [QW];
  logic [DW-1:0]     den_nxt  [QW];
  logic [QW-1:0]     quot_nxt [QW];
  logic [SIDE_W-1:0] side_nxt [QW];

  always_comb begin
    logic [NW-1:0] rem_cur;
    logic [QW-1:0] quot_cur;
    logic [NW-1:0] trial;
    logic          fits;
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_cur     = in_num;
        quot_cur    = '0;
        den_nxt[j]  = in_den;
        side_nxt[j] = in_side;
      end else begin
        rem_cur     = rem_r[j-1];
        quot_cur    = quot_r[j-1];
        den_nxt[j]  = den_r[j-1];
        side_nxt[j] = side_r[j-1];
      end
      trial       = NW'(den_nxt[j]) << (QW - 1 - j);
      fits        = rem_cur >= trial;
      rem_nxt[j]  = fits ? rem_cur - trial : rem_cur;
      quot_nxt[j] = {quot_cur[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_r[j]  <= rem_nxt[j];
        den_r[j]  <= den_nxt[j];
        quot_r[j] <= quot_nxt[j];
        side_r[j] <= side_nxt[j];
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot  = quot_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

// File: rtl/radial_alpha_mask_pixel.sv
// ----------------------------------------------------------------------------
// radial_alpha_mask_pixel: 8-bit alpha of one pixel of a radial mask
// pipeline: input, axis, square, sum and classify registers, the square root
//   (18 stages at the default), select register, 8-stage divider, output register
// throughput: one request per cycle; all stages hold together while a result
//   waits at a stalled output
// reset: synchronous active-low, clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radial_alpha_mask_pixel #(
  parameter int MAX_RADIUS = ramp_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ramp_pkg::COORD_W-1:0]     in_pixel_column,
  input  logic [ramp_pkg::COORD_W-1:0]     in_pixel_row,
  // alpha results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ramp_pkg::ALPHA_W-1:0]     out_pixel_alpha,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ramp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ramp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // internal radius width: the register width, or less for a small maximum
  localparam int RW = ($clog2(MAX_RADIUS) < ramp_pkg::RADIUS_W) ?
                      $clog2(MAX_RADIUS) : ramp_pkg::RADIUS_W;
  localparam int HW   = RW + 1;
  localparam int SW   = RW + ramp_pkg::FRAC_W;
  localparam int DW   = (2 * RW > SW) ? 2 * RW : SW;
  localparam int NW   = DW + ramp_pkg::ALPHA_W;
  localparam int SQ_W = 2 * ramp_pkg::COORD_W;
  localparam int CW   = (ramp_pkg::DIST_W > 2 * HW) ? ramp_pkg::DIST_W : 2 * HW;

  // what becomes of a pixel once its distance is classified
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_OPAQUE,
    KIND_FADE
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic            squared;
    logic [2*RW-1:0] sq_num;
  } side_t;

  localparam int SIDE_W = $bits(side_t);
  localparam int KIND_W = $bits(kind_t);

  // configuration and derived geometry
  logic [RW-1:0]        radius;
  logic [2*RW-1:0]      radius_sq;
  logic [2*HW-1:0]      hole_sq;
  logic [2*HW-1:0]      fade_sq;
  logic [SW-1:0]        lin_den;
  logic [2*RW-1:0]      sq_den;
  ramp_pkg::cfg_flags_t flags;

  // whole pipeline moves unless a finished result is held back
  logic pipe_en;

  // stage registers
  logic                         v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [ramp_pkg::COORD_W-1:0] col1_r, row1_r;
  logic [ramp_pkg::COORD_W-1:0] dx2_r, dy2_r;
  logic [SQ_W-1:0]              dxx3_r, dyy3_r;
  logic [ramp_pkg::DIST_W-1:0]  dist4_r;
  side_t                        side5_r;
  logic [2*RW-1:0]              op5_r;
  kind_t                        kind6_r;
  logic [NW-1:0]                num6_r;
  logic [DW-1:0]                den6_r;
  logic                         out_valid_r;
  logic [ramp_pkg::ALPHA_W-1:0] out_alpha_r;

  // combinational next values
  logic [ramp_pkg::COORD_W-1:0] radius_ext;
  logic [ramp_pkg::COORD_W-1:0] dx_nxt, dy_nxt;
  logic [CW-1:0]                dist_cmp, r2_cmp, hole_cmp, fade_cmp;
  side_t                        side5_nxt;
  side_t                        sq_side_t;
  logic [SW-1:0]                lin_num;
  logic [DW-1:0]                num_sel, den_sel;
  logic [ramp_pkg::ALPHA_W-1:0] alpha_nxt;

  // square root and divider outputs
  logic                         sq_valid;
  logic [SW-1:0]                sq_root;
  logic [SIDE_W-1:0]            sq_side;
  logic                         dv_valid;
  logic [ramp_pkg::ALPHA_W-1:0] dv_quot;
  logic [KIND_W-1:0]            dv_side;

  ramp_cfg #(
    .MAX_RADIUS (MAX_RADIUS),
    .RW         (RW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .radius    (radius),
    .radius_sq (radius_sq),
    .hole_sq   (hole_sq),
    .fade_sq   (fade_sq),
    .lin_den   (lin_den),
    .sq_den    (sq_den),
    .flags     (flags)
  );

  assign pipe_en  = !(out_valid_r && out_stall);
  assign in_stall = !pipe_en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= sq_valid;
      out_valid_r <= dv_valid;
    end
  end

  // stage two: distance from the centre along each axis
  assign radius_ext = ramp_pkg::COORD_W'(radius);
  assign dx_nxt = (col1_r > radius_ext) ? col1_r - radius_ext : radius_ext - col1_r;
  assign dy_nxt = (row1_r > radius_ext) ? row1_r - radius_ext : radius_ext - row1_r;

  // stage five: compare the squared distance against rim, hole and fade edge
  assign dist_cmp = CW'(dist4_r);
  assign r2_cmp   = CW'(radius_sq);
  assign hole_cmp = CW'(hole_sq);
  assign fade_cmp = CW'(fade_sq);

  always_comb begin
    side5_nxt.squared = flags.squared_falloff;
    side5_nxt.sq_num  = radius_sq - dist4_r[2*RW-1:0];
    if (dist_cmp > r2_cmp) begin
      side5_nxt.kind = KIND_CLEAR;
    end else if (flags.hole_enable && dist_cmp < hole_cmp) begin
      side5_nxt.kind = KIND_CLEAR;
    end else if (flags.fade_enable && dist_cmp > fade_cmp) begin
      side5_nxt.kind = KIND_FADE;
    end else begin
      side5_nxt.kind = KIND_OPAQUE;
    end
  end

  // stage six: pick squared or linear fraction, scale the numerator by 255
  assign sq_side_t = side_t'(sq_side);
  assign lin_num   = {radius, {ramp_pkg::FRAC_W{1'b0}}} - sq_root;
  assign num_sel   = sq_side_t.squared ? DW'(sq_side_t.sq_num) : DW'(lin_num);
  assign den_sel   = sq_side_t.squared ? DW'(sq_den) : DW'(lin_den);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      col1_r  <= in_pixel_column;
      row1_r  <= in_pixel_row;
      dx2_r   <= dx_nxt;
      dy2_r   <= dy_nxt;
      dxx3_r  <= SQ_W'(dx2_r) * SQ_W'(dx2_r);
      dyy3_r  <= SQ_W'(dy2_r) * SQ_W'(dy2_r);
      dist4_r <= ramp_pkg::DIST_W'(dxx3_r) + ramp_pkg::DIST_W'(dyy3_r);
      side5_r <= side5_nxt;
      op5_r   <= dist4_r[2*RW-1:0];
      kind6_r <= sq_side_t.kind;
      num6_r  <= {num_sel, {ramp_pkg::ALPHA_W{1'b0}}} - NW'(num_sel);
      den6_r  <= den_sel;
    end
  end

  // square root of the squared distance, eight fraction bits
  ramp_sqrt #(
    .RW     (RW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v5_r),
    .in_op     (op5_r),
    .in_side   (side5_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // alpha = floor(255 * num / den)
  ramp_div #(
    .DW     (DW),
    .SIDE_W (KIND_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (v6_r),
    .in_num    (num6_r),
    .in_den    (den6_r),
    .in_side   (kind6_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // output register: fade quotient, or the fixed clear / opaque value
  always_comb begin
    case (kind_t'(dv_side))
      KIND_FADE:   alpha_nxt = dv_quot;
      KIND_OPAQUE: alpha_nxt = ramp_pkg::ALPHA_OPAQUE;
      KIND_CLEAR:  alpha_nxt = ramp_pkg::ALPHA_CLEAR;
      default:     alpha_nxt = ramp_pkg::ALPHA_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_alpha_r <= alpha_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_alpha = out_alpha_r;

`ifndef NO_ASSERTIONS
  // a fade pixel never yields a quotient above 255
  a_fade_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && kind6_r == KIND_FADE) |-> num6_r < {den6_r, {ramp_pkg::ALPHA_W{1'b0}}})
    else $error("fade numerator exceeds divisor range");

  // a held output freezes every stage valid bit
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r}))
    else $error("pipeline moved while output held");
`endif

endmodule

`default_nettype wire
